// ===== src/accel_magnitude_moving_average_core_assert.svh =====
// Assertion macros shared by the checker of the magnitude moving-average core.
`ifndef ACCEL_MAGNITUDE_MOVING_AVERAGE_CORE_ASSERT_SVH
`define ACCEL_MAGNITUDE_MOVING_AVERAGE_CORE_ASSERT_SVH

// Same-edge implication, clocked on aclk and off during reset.
`define AMMA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-edge implication, clocked on aclk and off during reset.
`define AMMA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/ammavg_pkg.sv =====
// Shared types and constants of the magnitude moving-average core.
`default_nettype none
package ammavg_pkg;

    localparam int COMP_W   = 16;
    localparam int MAG_W    = 16;
    localparam int SQ_W     = 32;
    localparam int SUM_W    = 23;
    localparam int IN_W     = 3 * COMP_W;
    localparam int OUT_W    = 2 * MAG_W;

    // Root: one result bit per step.
    localparam int ROOT_STEPS = 16;
    localparam int STEP_W     = 4;

    localparam logic OP_ACCEL = 1'b0;
    localparam logic OP_OTHER = 1'b1;

    typedef struct packed {
        logic load_vec;
        logic square;
        logic init_root;
        logic root_step;
        logic update;
        logic div_step;
        logic out_load;
    } ammavg_cmd_t;

    typedef struct packed {
        logic out_free;
    } ammavg_status_t;

endpackage
`default_nettype wire

// ===== src/ammavg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ammavg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 100
) (
    input  wire logic                                  aclk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== src/ammavg_ctrl.sv =====
// Controller: sequences one event through square, root, window update and divide.
`default_nettype none
module ammavg_ctrl
    import ammavg_pkg::*;
(
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic           s_tuser,
    input  wire ammavg_status_t status,
    output ammavg_cmd_t         cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SQUARE = 3'd1;
    localparam logic [2:0] S_TOTAL  = 3'd2;
    localparam logic [2:0] S_ROOT   = 3'd3;
    localparam logic [2:0] S_UPDATE = 3'd4;
    localparam logic [2:0] S_DIVIDE = 3'd5;
    localparam logic [2:0] S_OUTPUT = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_vec = (s_tuser == OP_ACCEL);
                    state_next   = S_SQUARE;
                end
            end
            S_SQUARE: begin
                cmd.square = 1'b1;
                state_next = S_TOTAL;
            end
            S_TOTAL: begin
                cmd.init_root = 1'b1;
                step_next     = '0;
                state_next    = S_ROOT;
            end
            S_ROOT: begin
                cmd.root_step = 1'b1;
                if (step_reg == STEP_W'(ROOT_STEPS - 1)) begin
                    step_next  = '0;
                    state_next = S_UPDATE;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_UPDATE: begin
                cmd.update = 1'b1;
                state_next = S_DIVIDE;
            end
            S_DIVIDE: begin
                cmd.div_step = 1'b1;
                state_next   = S_OUTPUT;
            end
            S_OUTPUT: begin
                // Hold until the output register can take the word.
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/ammavg_datapath.sv =====
// Datapath: vector store, squares, iterative root, sample window, divider, output register.
`default_nettype none
module ammavg_datapath
    import ammavg_pkg::*;
#(
    parameter int WINDOW = 100
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [IN_W-1:0]  s_tdata,
    input  wire ammavg_cmd_t      cmd,
    output ammavg_status_t        status,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [OUT_W-1:0]      m_tdata
);

    localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    // Divide by WINDOW as a multiply by a rounded-up reciprocal; exact for any SUM_W-bit sum.
    localparam int     RECIP_L     = $clog2(WINDOW);
    localparam int     RECIP_SHIFT = SUM_W + RECIP_L;
    localparam int     RECIP_W     = SUM_W + 1;
    localparam int     PROD_W      = SUM_W + RECIP_W;
    localparam longint RECIP_VAL   =
        ((longint'(1) << RECIP_SHIFT) + longint'(WINDOW) - 1) / longint'(WINDOW);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

    logic signed [COMP_W-1:0] vec_x_reg, vec_y_reg, vec_z_reg;
    logic signed [SQ_W-1:0]   sq_x_reg, sq_y_reg, sq_z_reg;
    logic [SQ_W-1:0]          rem_reg, res_reg, bit_reg;
    logic [MAG_W-1:0]         old_reg;
    logic [SUM_W-1:0]         sum_reg, sum_next;
    logic [POS_W-1:0]         pos_reg;
    logic [WINDOW-1:0]        valid_reg;
    logic [MAG_W-1:0]         avg_reg;
    logic [PROD_W-1:0]        avg_prod;
    logic                     m_tvalid_reg;
    logic [OUT_W-1:0]         m_tdata_reg;
    logic [MAG_W-1:0]         ram_rdata;
    logic [MAG_W-1:0]         mag;
    logic [SQ_W:0]            trial;
    logic                     trial_fits;

    assign mag = res_reg[MAG_W-1:0];

    ammavg_ram #(
        .WIDTH(MAG_W),
        .DEPTH(WINDOW)
    ) u_window_ram (
        .aclk (aclk),
        .we   (cmd.update),
        .waddr(pos_reg),
        .wdata(mag),
        .raddr(pos_reg),
        .rdata(ram_rdata)
    );

    // Root step: try res + bit against the remainder.
    assign trial      = {1'b0, res_reg} + {1'b0, bit_reg};
    assign trial_fits = ({1'b0, rem_reg} >= trial);

    assign sum_next = sum_reg - SUM_W'(old_reg) + SUM_W'(mag);

    assign avg_prod = PROD_W'(sum_reg) * PROD_W'(RECIP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vec_x_reg <= '0;
            vec_y_reg <= '0;
            vec_z_reg <= '0;
            sum_reg   <= '0;
            pos_reg   <= '0;
            valid_reg <= '0;
        end else begin
            if (cmd.load_vec) begin
                vec_x_reg <= s_tdata[COMP_W-1:0];
                vec_y_reg <= s_tdata[2*COMP_W-1:COMP_W];
                vec_z_reg <= s_tdata[3*COMP_W-1:2*COMP_W];
            end
            if (cmd.update) begin
                sum_reg            <= sum_next;
                valid_reg[pos_reg] <= 1'b1;
                if (pos_reg == POS_W'(WINDOW - 1)) begin
                    pos_reg <= '0;
                end else begin
                    pos_reg <= pos_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.square) begin
            sq_x_reg <= vec_x_reg * vec_x_reg;
            sq_y_reg <= vec_y_reg * vec_y_reg;
            sq_z_reg <= vec_z_reg * vec_z_reg;
        end
        if (cmd.init_root) begin
            rem_reg <= SQ_W'(unsigned'(sq_x_reg)) + SQ_W'(unsigned'(sq_y_reg))
                       + SQ_W'(unsigned'(sq_z_reg));
            res_reg <= '0;
            bit_reg <= SQ_W'(1) << (SQ_W - 2);
            // Slots never written read as zero.
            old_reg <= valid_reg[pos_reg] ? ram_rdata : '0;
        end
        if (cmd.root_step) begin
            if (trial_fits) begin
                rem_reg <= rem_reg - trial[SQ_W-1:0];
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.div_step) begin
            avg_reg <= avg_prod[RECIP_SHIFT +: MAG_W];
        end
        if (cmd.out_load) begin
            m_tdata_reg <= {avg_reg, mag};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign status.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid        = m_tvalid_reg;
    assign m_tdata         = m_tdata_reg;

endmodule
`default_nettype wire

// ===== src/accel_magnitude_moving_average_core.sv =====
// Acceleration magnitude with boxcar moving average: top level.
//
// Input stream: one word per sensor event. s_tuser is the report kind
// (0 = linear acceleration, 1 = other). s_tdata carries x, y, z in signed Q8.8.
// An acceleration report replaces the stored vector; every event then emits
// one result word on the m_ side: the truncated root of the sum of squares
// of the stored vector and the average over the last WINDOW magnitudes
// (slots not yet written count as zero).
// Steps: once the input word is taken the core computes the squares, sums
// them, runs 16 root steps (one result bit per cycle), updates the window,
// does one reciprocal multiply for the divide by WINDOW and loads the output
// register, waiting there while it is full. s_tready rises again the cycle
// after the output load, so one event is taken at a time; root steps dominate.
// The result sits in an output register: a stalled receiver does not block
// the next event, which runs until it needs that register and then waits.
// Reset (aresetn low, synchronous) clears the vector, the running sum, the
// window position and the per-slot valid bits, so no clearing pass is needed.
`default_nettype none
module accel_magnitude_moving_average_core
    import ammavg_pkg::*;
#(
    parameter int WINDOW = 100
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [IN_W-1:0]  s_tdata,   // accel_x, accel_y, accel_z
    input  wire logic             s_tuser,   // operation
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [OUT_W-1:0]      m_tdata    // magnitude, window_average
);

    ammavg_cmd_t    cmd;
    ammavg_status_t status;

    ammavg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tuser (s_tuser),
        .status  (status),
        .cmd     (cmd)
    );

    ammavg_datapath #(
        .WINDOW(WINDOW)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .status  (status),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

endmodule
`default_nettype wire

// ===== src/ammavg_checker.sv =====
// Port-level checker for the magnitude moving-average core, with its bind.
`default_nettype none
`include "accel_magnitude_moving_average_core_assert.svh"
module ammavg_checker
    import ammavg_pkg::*;
(
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_tvalid,
    input wire logic             s_tready,
    input wire logic             s_tuser,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [OUT_W-1:0] m_tdata
);

    logic [1:0] pending_reg;
    logic       in_fire;
    logic       out_fire;
    logic       kind_seen;

    assign in_fire   = s_tvalid && s_tready;
    assign out_fire  = m_tvalid && m_tready;
    assign kind_seen = (s_tuser == OP_ACCEL) || (s_tuser == OP_OTHER);

    // Count words taken but not yet delivered.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else if (in_fire && !out_fire) begin
            pending_reg <= pending_reg + 1'b1;
        end else if (out_fire && !in_fire) begin
            pending_reg <= pending_reg - 1'b1;
        end
    end

    `AMMA_ASSERT_NOW(a_no_invented_result, out_fire, pending_reg != 2'd0)
    `AMMA_ASSERT_NOW(a_pending_bound, kind_seen || !kind_seen, pending_reg <= 2'd2)
    `AMMA_ASSERT_NEXT(a_one_at_a_time, in_fire, !s_tready)
    `AMMA_ASSERT_NOW(a_result_range, m_tvalid, (m_tdata[15:0] <= 16'd56755) && (m_tdata[31:16] <= 16'd56755))
    `AMMA_ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind accel_magnitude_moving_average_core ammavg_checker u_checker (.*);
`default_nettype wire
